### rtl/utf8_to_code_point_decoder_defines.svh
// Assertion macros used by the UTF-8 decoder core.
`ifndef UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODE_POINT_DECODER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define U8DEC_ASSERT_NOW(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
        else $error("u8dec: same-cycle check failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define U8DEC_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error("u8dec: next-cycle check failed");

`endif

### rtl/u8dec_pkg.sv
// Types and constants shared by the UTF-8 decoder modules.
package u8dec_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned PEND_W = 2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    // One input beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_in;
        logic              end_of_text;
    } byte_beat_t;

    // One result beat
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
        logic            end_flag;
    } cp_beat_t;

    // Input register contents handed to the decode stage
    typedef struct packed {
        logic       valid;
        byte_beat_t beat;
    } stage_t;

endpackage

### rtl/u8dec_byte_if.sv
// Valid/ready channel carrying raw UTF-8 byte beats.
interface u8dec_byte_if;
    logic                  valid;
    logic                  ready;
    u8dec_pkg::byte_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/u8dec_cp_if.sv
// Valid/ready channel carrying decoded code point beats.
interface u8dec_cp_if;
    logic                valid;
    logic                ready;
    u8dec_pkg::cp_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/utf8_to_code_point_decoder.sv
// An accepted byte is held in the input register; its result, if any, goes to the result register.
// One byte per cycle while the output is ready; input and result registers let a new byte
// enter while a finished code point waits on the output.
// The decode path is one compare/shift between the input and result registers.
// Reset (rst_n low, asynchronous) empties both stages and clears sequence state.
module utf8_to_code_point_decoder (
    input  logic        clk,
    input  logic        rst_n,
    u8dec_byte_if.sink  byte_ch,
    u8dec_cp_if.source  code_ch
);
    import u8dec_pkg::*;

    stage_t stage;
    logic   take;

    u8dec_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .take    (take),
        .stage   (stage)
    );

    u8dec_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .take    (take),
        .code_ch (code_ch)
    );

endmodule

### rtl/u8dec_in_reg.sv
// Input register stage: captures one byte beat per cycle while empty or while the decode stage takes the held beat.
module u8dec_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    u8dec_byte_if.sink          byte_ch,
    input  logic                take,
    output u8dec_pkg::stage_t   stage
);
    import u8dec_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_beat_t beat_reg;
    logic       load;

    // Room when empty or when the decode stage consumes the held beat
    assign byte_ch.ready = !valid_reg || take;
    assign load          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= byte_ch.payload;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

### rtl/u8dec_core.sv
// Decode stage: sequence state, byte decode and result register.
`include "utf8_to_code_point_decoder_defines.svh"

module u8dec_core (
    input  logic                clk,
    input  logic                rst_n,
    input  u8dec_pkg::stage_t   stage,
    output logic                take,
    u8dec_cp_if.source          code_ch
);
    import u8dec_pkg::*;

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic [CP_W-1:0]   partial_reg;
    logic [CP_W-1:0]   partial_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cp_beat_t          out_reg;

    logic [BYTE_W-1:0] b;
    logic              eot;
    logic [CP_W-1:0]   shifted;
    logic [PEND_W-1:0] pend_dec;
    logic              emit;
    cp_beat_t          res;
    logic [PEND_W-1:0] dec_pend;
    logic [CP_W-1:0]   dec_val;

    assign b   = stage.beat.byte_in;
    assign eot = stage.beat.end_of_text;

    // Consume the held beat when the result register is free or draining
    assign take = stage.valid && (!out_valid_reg || code_ch.ready);

    assign shifted  = {partial_reg[CP_W-7:0], b[5:0]};
    assign pend_dec = pending_reg - 2'd1;

    // Decode one byte against the current sequence state
    always_comb
    begin
        emit         = 1'b0;
        res          = '0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        dec_pend     = '0;
        dec_val      = '0;

        if (pending_reg != '0)
        begin
            // Continuation: shift in six payload bits
            if (pend_dec == '0)
            begin
                emit           = 1'b1;
                res.code_point = shifted;
                res.status     = ST_OK;
                res.end_flag   = eot;
                pending_next   = '0;
                partial_next   = '0;
            end
            else if (eot)
            begin
                emit           = 1'b1;
                res.code_point = shifted;
                res.status     = ST_TRUNC;
                res.end_flag   = 1'b1;
                pending_next   = '0;
                partial_next   = '0;
            end
            else
            begin
                pending_next = pend_dec;
                partial_next = shifted;
            end
        end
        else
        begin
            // Lead byte classification
            if (b[7] == 1'b0)
            begin
                emit           = 1'b1;
                res.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
                res.status     = ST_OK;
                res.end_flag   = eot;
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    dec_pend = 2'd1;
                    dec_val  = {{(CP_W-5){1'b0}}, b[4:0]};
                end
                else if (b[7:4] == 4'b1110)
                begin
                    dec_pend = 2'd2;
                    dec_val  = {{(CP_W-4){1'b0}}, b[3:0]};
                end
                else if (b[7:3] == 5'b11110)
                begin
                    dec_pend = 2'd3;
                    dec_val  = {{(CP_W-3){1'b0}}, b[2:0]};
                end

                if (dec_pend == '0)
                begin
                    // Cannot lead: pass through as invalid
                    emit           = 1'b1;
                    res.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
                    res.status     = ST_INVALID;
                    res.end_flag   = eot;
                end
                else if (eot)
                begin
                    emit           = 1'b1;
                    res.code_point = dec_val;
                    res.status     = ST_TRUNC;
                    res.end_flag   = 1'b1;
                end
                else
                begin
                    pending_next = dec_pend;
                    partial_next = dec_val;
                end
            end
        end
    end

    // Result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (code_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            partial_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= res;
        end
    end

    assign code_ch.valid   = out_valid_reg;
    assign code_ch.payload = out_reg;

    // Checks
    `U8DEC_ASSERT_NOW(a_trunc_ends, out_valid_reg && (out_reg.status == ST_TRUNC), out_reg.end_flag)
    `U8DEC_ASSERT_NEXT(a_eot_clears, take && eot, pending_reg == '0)
    `U8DEC_ASSERT_NEXT(a_eot_result, take && eot, out_valid_reg && out_reg.end_flag)
    `U8DEC_ASSERT_NOW(a_idle_partial, pending_reg == '0, partial_reg == '0)
    `U8DEC_ASSERT_NOW(a_invalid_byte, out_valid_reg && (out_reg.status == ST_INVALID), out_reg.code_point[CP_W-1:BYTE_W] == '0)

endmodule

### verif/utf8_to_code_point_decoder_checker.sv
// Checker for the UTF-8 decoder: watches both channels, predicts code points, compares results.
module utf8_to_code_point_decoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    u8dec_byte_if       byte_ch,
    u8dec_cp_if         code_ch,
    output int          fail_count,
    output int          pending_cps
);
    timeunit 1ns;
    timeprecision 1ps;

    import u8dec_pkg::*;

    // Decoder state as seen from outside
    logic [PEND_W-1:0] conts_left;
    logic [CP_W-1:0]   acc_cp;
    cp_beat_t          expected_cps[$];
    cp_beat_t          want;
    cp_beat_t          got;

    // Apply one byte to the predicted decoder state, queue a code point if one comes out
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
        cp_beat_t r;
        logic     emit;
        logic     lead_started;
        emit         = 1'b0;
        lead_started = 1'b0;
        r            = '0;
        r.end_flag   = eot;
        if (conts_left != '0)
        begin
            // any byte counts as a continuation, low six bits only
            acc_cp     = {acc_cp[CP_W-7:0], b[5:0]};
            conts_left = conts_left - 1'b1;
            if (conts_left == '0)
            begin
                emit         = 1'b1;
                r.code_point = acc_cp;
                r.status     = ST_OK;
                acc_cp       = '0;
            end
            else if (eot)
            begin
                emit         = 1'b1;
                r.code_point = acc_cp;
                r.status     = ST_TRUNC;
                conts_left   = '0;
                acc_cp       = '0;
            end
        end
        else if (!b[7])
        begin
            emit         = 1'b1;
            r.code_point = CP_W'(b);
            r.status     = ST_OK;
        end
        else if (b[7:5] == 3'b110)
        begin
            conts_left   = 2'd1;
            acc_cp       = CP_W'(b[4:0]);
            lead_started = 1'b1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            conts_left   = 2'd2;
            acc_cp       = CP_W'(b[3:0]);
            lead_started = 1'b1;
        end
        else if (b[7:3] == 5'b11110)
        begin
            conts_left   = 2'd3;
            acc_cp       = CP_W'(b[2:0]);
            lead_started = 1'b1;
        end
        else
        begin
            // cannot lead: passed through as is
            emit         = 1'b1;
            r.code_point = CP_W'(b);
            r.status     = ST_INVALID;
        end
        // text ends right on a multi-byte lead
        if (lead_started && eot)
        begin
            emit         = 1'b1;
            r.code_point = acc_cp;
            r.status     = ST_TRUNC;
            conts_left   = '0;
            acc_cp       = '0;
        end
        if (emit)
            expected_cps.push_back(r);
    endtask

    // Predict on accepted bytes, compare accepted code points
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conts_left = '0;
            acc_cp     = '0;
            expected_cps.delete();
            fail_count = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                decode_byte(byte_ch.payload.byte_in, byte_ch.payload.end_of_text);
            if (code_ch.valid && code_ch.ready)
            begin
                got = code_ch.payload;
                if (expected_cps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected code point beat: expected none, got cp=%h st=%0d end=%b",
                             $time, got.code_point, got.status, got.end_flag);
                end
                else
                begin
                    want = expected_cps.pop_front();
                    if (got.code_point !== want.code_point)
                    begin
                        fail_count++;
                        $display("%0t: code_point mismatch: expected %h, got %h",
                                 $time, want.code_point, got.code_point);
                    end
                    if (got.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.end_flag !== want.end_flag)
                    begin
                        fail_count++;
                        $display("%0t: end_flag mismatch: expected %b, got %b",
                                 $time, want.end_flag, got.end_flag);
                    end
                end
            end
        end
        pending_cps = expected_cps.size();
    end

endmodule

### verif/utf8_to_code_point_decoder_tb.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus, result stalls, verdict.
module utf8_to_code_point_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS      = 1450;
    localparam int WDOG_LIMIT   = 1000;
    localparam int STALL_START  = 300;
    localparam int STALL_LEN    = 80;
    localparam int RX_CALM_LO   = 900;
    localparam int RX_CALM_HI   = 1300;
    localparam int TX_CALM_LO   = 700;
    localparam int TX_CALM_HI   = 1000;
    localparam int IDLE_PCT     = 24;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_cps;
    int   sent;

    u8dec_byte_if byte_ch ();
    u8dec_cp_if   code_ch ();

    utf8_to_code_point_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .code_ch (code_ch)
    );

    utf8_to_code_point_decoder_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_ch     (byte_ch),
        .code_ch     (code_ch),
        .fail_count  (fail_count),
        .pending_cps (pending_cps)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Lead byte for a sequence of len bytes (2..4), random payload bits
    function automatic logic [7:0] mb_lead(input int unsigned len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Offer one byte beat, with random gaps unless calm, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b, input logic eot, input bit calm);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= {b, eot};
        do
            @(posedge clk);
        while (!byte_ch.ready);
        sent++;
    endtask

    // Byte sequence with end of text at one position (none if eot_pos < 0)
    task automatic send_seq(input byte_q_t seq, input int eot_pos, input bit calm);
        foreach (seq[i])
            send_byte(seq[i], i == eot_pos, calm);
    endtask

    // Result side: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int rx_cycle;
        rx_cycle = 0;
        code_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_cycle >= STALL_START && rx_cycle < STALL_START + STALL_LEN)
                code_ch.ready <= 1'b0;
            else if (rx_cycle >= RX_CALM_LO && rx_cycle < RX_CALM_HI)
                code_ch.ready <= 1'b1;
            else
                code_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
            rx_cycle++;
        end
    end

    // Watchdog: too long with no beat on either channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid && byte_ch.ready) || (code_ch.valid && code_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Byte stimulus and verdict
    initial
    begin
        byte_q_t seq;
        int      pick;
        int      len;
        int      eot_pos;
        bit      calm;
        sent = 0;
        rst_n = 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every length, invalid leads, unchecked
        // continuations, end of text on lead, mid-sequence and last byte
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b1, 1'b0);
        send_seq({8'hC2, 8'hA9}, -1, 1'b0);
        send_seq({8'hEF, 8'hBF, 8'hBF}, -1, 1'b0);
        send_seq({8'hF7, 8'hBF, 8'hBF, 8'hBF}, 3, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hF8, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b0);
        send_seq({8'hC3, 8'h41}, -1, 1'b0);
        send_byte(8'hE2, 1'b1, 1'b0);
        send_seq({8'hF0, 8'h9F}, 1, 1'b0);
        send_seq({8'hDF, 8'h00}, -1, 1'b0);

        // Random: mostly well-formed sequences, some invalid, broken and noise
        while (sent < N_ITEMS)
        begin
            seq  = {};
            pick = $urandom_range(99);
            calm = (sent >= TX_CALM_LO && sent < TX_CALM_HI);
            if (pick < 25)
                seq.push_back({1'b0, 7'($urandom)});
            else if (pick < 78)
            begin
                len = (pick < 45) ? 2 : (pick < 62) ? 3 : 4;
                seq.push_back(mb_lead(len));
                repeat (len - 1)
                    seq.push_back({2'b10, 6'($urandom)});
            end
            else if (pick < 86)
                seq.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                : 8'($urandom_range(8'hFF, 8'hF8)));
            else if (pick < 93)
            begin
                // lead followed by arbitrary bytes
                len = $urandom_range(4, 2);
                seq.push_back(mb_lead(len));
                repeat ($urandom_range(len - 1, 1))
                    seq.push_back(8'($urandom));
            end
            else
                repeat ($urandom_range(3, 1))
                    seq.push_back(8'($urandom));
            eot_pos = -1;
            if ($urandom_range(19) == 0)
                eot_pos = seq.size() - 1;
            else if ($urandom_range(24) == 0)
                eot_pos = $urandom_range(seq.size() - 1);
            send_seq(seq, eot_pos, calm);
        end
        byte_ch.valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending_cps != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_cps == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
